// ===== hdl/calendar_time_adjust_macros.svh =====
// Assertion macros for the calendar time adjust block.
// Sampled on clk, disabled while rst_n is low; define NO_ASSERTIONS to drop them.
`ifndef CALENDAR_TIME_ADJUST_MACROS_SVH
`define CALENDAR_TIME_ADJUST_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CTA_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("calendar_time_adjust: assertion failed");

`define CTA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("calendar_time_adjust: implication failed");

`else

`define CTA_ASSERT(lbl, expr)

`define CTA_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

// ===== hdl/cta_pkg.sv =====
// Shared types, codes and calendar constants for the calendar time adjust block.
// Used by cta_divc and calendar_time_adjust; depends on nothing.
package cta_pkg;

  localparam int YEAR_BITS_DEF  = 14;
  localparam int DELTA_BITS_DEF = 21;
  localparam int DIV_W_DEF      = DELTA_BITS_DEF + 2;

  localparam int SEC_PER_MIN  = 60;
  localparam int HOUR_PER_DAY = 24;
  localparam logic [6:0] DIV_MIN  = 7'(SEC_PER_MIN);
  localparam logic [6:0] DIV_HOUR = 7'(HOUR_PER_DAY);

  localparam logic [3:0] MONTH_FEB  = 4'd1;
  localparam logic [3:0] MONTH_LAST = 4'd11;
  localparam logic [3:0] MONTH_TOP  = 4'd13;

  localparam logic [1:0] REQ_SET = 2'd0;
  localparam logic [1:0] REQ_ADD = 2'd1;
  localparam logic [1:0] REQ_CMP = 2'd2;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic start;
    logic by_hour;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic logic [4:0] days_of(input logic [3:0] mo, input logic leap);
    logic [4:0] len;
    if (mo == MONTH_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (mo > MONTH_LAST) begin
      len = 5'd31;
    end else begin
      len = MONTH_LEN[mo];
    end
    return len;
  endfunction

endpackage

// ===== hdl/calendar_time_adjust.sv =====
// Calendar date and time register with set, add-seconds and compare requests.
// Depends on cta_pkg, cta_divc and calendar_time_adjust_macros.svh.
//
// One request is in work at a time; in_stall stays high until its result is loaded
// into the output register, which then waits for the taker while the next request
// is accepted. The seconds, minutes and hours carries run one after another through
// one shared divider by 60 or 24 (reciprocal multiply), each carry stepping through
// S_DIVGO and S_DIVW; the day carry then walks month by month, one month per cycle,
// and S_FIN loads the result. A delta spans about twelve days at the default widths,
// so at most one month boundary is crossed. in_stall also stays high while a result
// waits in S_FIN because the output register is still held by out_stall. An unused
// request code skips the divider and the day carry and goes straight to S_FIN.
`include "calendar_time_adjust_macros.svh"

module calendar_time_adjust
  import cta_pkg::*;
#(
  parameter int YEAR_BITS  = YEAR_BITS_DEF,
  parameter int DELTA_BITS = DELTA_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_req_type,
  input  logic [YEAR_BITS-1:0]  in_year,
  input  logic [3:0]            in_month,
  input  logic [4:0]            in_day,
  input  logic [4:0]            in_hour,
  input  logic [5:0]            in_minute,
  input  logic [5:0]            in_second,
  input  logic [DELTA_BITS-1:0] in_delta_seconds,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [YEAR_BITS-1:0]  out_year,
  output logic [3:0]            out_month,
  output logic [4:0]            out_day,
  output logic [4:0]            out_hour,
  output logic [5:0]            out_minute,
  output logic [5:0]            out_second,
  output logic [1:0]            out_order,
  output logic                  out_year_overflow
);

  localparam int W  = DELTA_BITS + 2;
  localparam int YW = YEAR_BITS + 2;

  localparam longint unsigned HALF = 64'd1 << (DELTA_BITS - 1);
  localparam longint unsigned K60  = (HALF + SEC_PER_MIN - 1) / SEC_PER_MIN;
  localparam longint unsigned K24  = (HALF + HOUR_PER_DAY - 1) / HOUR_PER_DAY;
  localparam logic [W-1:0] K60_W   = W'(K60);
  localparam logic [W-1:0] K24_W   = W'(K24);
  localparam logic [W-1:0] OFF60_W = W'(K60 * SEC_PER_MIN);
  localparam logic [W-1:0] OFF24_W = W'(K24 * HOUR_PER_DAY);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIVGO = 3'd1;
  localparam logic [2:0] S_DIVW  = 3'd2;
  localparam logic [2:0] S_DAY   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam logic [1:0] STG_SEC  = 2'd0;
  localparam logic [1:0] STG_MIN  = 2'd1;
  localparam logic [1:0] STG_HOUR = 2'd2;

  logic [2:0] state_r;
  logic [1:0] stage_r;
  logic [1:0] req_r;

  logic signed [W-1:0]  sc_w_r, mt_w_r, hr_w_r, dy_w_r;
  logic [3:0]           mo_w_r;
  logic signed [YW-1:0] y_w_r;

  logic [YEAR_BITS-1:0] year_reg_r;
  logic [3:0]           month_reg_r;
  logic [4:0]           day_reg_r;
  logic [4:0]           hour_reg_r;
  logic [5:0]           minute_reg_r;
  logic [5:0]           second_reg_r;

  logic                 out_valid_r;
  logic [YEAR_BITS-1:0] out_year_r;
  logic [3:0]           out_month_r;
  logic [4:0]           out_day_r;
  logic [4:0]           out_hour_r;
  logic [5:0]           out_minute_r;
  logic [5:0]           out_second_r;
  logic [1:0]           out_order_r;
  logic                 out_ovf_r;

  div_ctl_t     div_ctl;
  div_sts_t     div_sts;
  logic [W-1:0] div_operand;
  logic [W-1:0] div_q;
  logic [5:0]   div_rem;
  logic signed [W-1:0] q_adj;

  logic                 accept;
  logic                 out_free;
  logic [3:0]           set_mo;
  logic signed [YW-1:0] set_y;
  logic [3:0]           prev_mo, next_mo;
  logic signed [YW-1:0] prev_y, next_y;
  logic signed [W-1:0]  cur_len, prev_len;
  logic                 y_ovf;
  logic                 is_upd;
  logic                 commit;
  logic [1:0]           rank;
  logic signed [YW-1:0] stored_y;
  logic [25:0]          stored_low, given_low;
  logic                 fields_legal;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  cta_divc #(.WIDTH(W)) u_divc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (div_operand),
    .sts       (div_sts),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign div_ctl.start   = (state_r == S_DIVGO);
  assign div_ctl.by_hour = (stage_r == STG_HOUR);

  always_comb begin
    case (stage_r)
      STG_SEC:  div_operand = sc_w_r + OFF60_W;
      STG_MIN:  div_operand = mt_w_r + OFF60_W;
      default:  div_operand = hr_w_r + OFF24_W;
    endcase
  end

  assign q_adj = $signed(div_q) - $signed((stage_r == STG_HOUR) ? K24_W : K60_W);

  always_comb begin
    if (in_month == 4'd0) begin
      set_mo = MONTH_LAST;
      set_y  = $signed({2'b00, in_year}) - YW'(1);
    end else if (in_month >= MONTH_TOP) begin
      set_mo = in_month - MONTH_TOP;
      set_y  = $signed({2'b00, in_year}) + YW'(1);
    end else begin
      set_mo = in_month - 4'd1;
      set_y  = $signed({2'b00, in_year});
    end
  end

  assign prev_mo  = (mo_w_r == 4'd0) ? MONTH_LAST : mo_w_r - 4'd1;
  assign prev_y   = (mo_w_r == 4'd0) ? y_w_r - YW'(1) : y_w_r;
  assign next_mo  = (mo_w_r == MONTH_LAST) ? 4'd0 : mo_w_r + 4'd1;
  assign next_y   = (mo_w_r == MONTH_LAST) ? y_w_r + YW'(1) : y_w_r;
  assign cur_len  = $signed({{(W-5){1'b0}}, days_of(mo_w_r, y_w_r[1:0] == 2'b00)});
  assign prev_len = $signed({{(W-5){1'b0}}, days_of(prev_mo, prev_y[1:0] == 2'b00)});

  assign y_ovf  = y_w_r[YW-1] || y_w_r[YW-2];
  assign is_upd = (req_r == REQ_SET) || (req_r == REQ_ADD);
  assign commit = is_upd && !y_ovf;

  assign stored_y   = $signed({2'b00, year_reg_r});
  assign stored_low = {month_reg_r, day_reg_r, hour_reg_r, minute_reg_r, second_reg_r};
  assign given_low  = {mo_w_r, dy_w_r[4:0], hr_w_r[4:0], mt_w_r[5:0], sc_w_r[5:0]};

  always_comb begin
    if (stored_y < y_w_r) begin
      rank = ORD_LT;
    end else if (stored_y > y_w_r) begin
      rank = ORD_GT;
    end else if (stored_low < given_low) begin
      rank = ORD_LT;
    end else if (stored_low > given_low) begin
      rank = ORD_GT;
    end else begin
      rank = ORD_EQ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      stage_r      <= STG_SEC;
      year_reg_r   <= '0;
      month_reg_r  <= '0;
      day_reg_r    <= '0;
      hour_reg_r   <= '0;
      minute_reg_r <= '0;
      second_reg_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          stage_r <= STG_SEC;
          if (accept) begin
            if (in_req_type == REQ_SET || in_req_type == REQ_ADD ||
                in_req_type == REQ_CMP) begin
              state_r <= S_DIVGO;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_DIVGO: begin
          state_r <= S_DIVW;
        end
        S_DIVW: begin
          if (div_sts.done) begin
            stage_r <= stage_r + 2'd1;
            state_r <= (stage_r == STG_HOUR) ? S_DAY : S_DIVGO;
          end
        end
        S_DAY: begin
          if (!dy_w_r[W-1] && (dy_w_r < cur_len)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
            if (commit) begin
              year_reg_r   <= y_w_r[YEAR_BITS-1:0];
              month_reg_r  <= mo_w_r;
              day_reg_r    <= dy_w_r[4:0];
              hour_reg_r   <= hr_w_r[4:0];
              minute_reg_r <= mt_w_r[5:0];
              second_reg_r <= sc_w_r[5:0];
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_r <= in_req_type;
          if (in_req_type == REQ_ADD) begin
            sc_w_r <= $signed({{(W-6){1'b0}}, second_reg_r})
                      + $signed({{2{in_delta_seconds[DELTA_BITS-1]}}, in_delta_seconds});
            mt_w_r <= $signed({{(W-6){1'b0}}, minute_reg_r});
            hr_w_r <= $signed({{(W-5){1'b0}}, hour_reg_r});
            dy_w_r <= $signed({{(W-5){1'b0}}, day_reg_r});
            mo_w_r <= month_reg_r;
            y_w_r  <= stored_y;
          end else begin
            sc_w_r <= $signed({{(W-6){1'b0}}, in_second});
            mt_w_r <= $signed({{(W-6){1'b0}}, in_minute});
            hr_w_r <= $signed({{(W-5){1'b0}}, in_hour});
            dy_w_r <= $signed({{(W-5){1'b0}}, in_day}) - W'(1);
            mo_w_r <= set_mo;
            y_w_r  <= set_y;
          end
        end
      end
      S_DIVW: begin
        if (div_sts.done) begin
          case (stage_r)
            STG_SEC: begin
              sc_w_r <= $signed({{(W-6){1'b0}}, div_rem});
              mt_w_r <= mt_w_r + q_adj;
            end
            STG_MIN: begin
              mt_w_r <= $signed({{(W-6){1'b0}}, div_rem});
              hr_w_r <= hr_w_r + q_adj;
            end
            default: begin
              hr_w_r <= $signed({{(W-6){1'b0}}, div_rem});
              dy_w_r <= dy_w_r + q_adj;
            end
          endcase
        end
      end
      S_DAY: begin
        if (dy_w_r[W-1]) begin
          mo_w_r <= prev_mo;
          y_w_r  <= prev_y;
          dy_w_r <= dy_w_r + prev_len;
        end else if (dy_w_r >= cur_len) begin
          mo_w_r <= next_mo;
          y_w_r  <= next_y;
          dy_w_r <= dy_w_r - cur_len;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_year_r   <= commit ? y_w_r[YEAR_BITS-1:0] : year_reg_r;
          out_month_r  <= (commit ? mo_w_r : month_reg_r) + 4'd1;
          out_day_r    <= (commit ? dy_w_r[4:0] : day_reg_r) + 5'd1;
          out_hour_r   <= commit ? hr_w_r[4:0] : hour_reg_r;
          out_minute_r <= commit ? mt_w_r[5:0] : minute_reg_r;
          out_second_r <= commit ? sc_w_r[5:0] : second_reg_r;
          out_order_r  <= (req_r == REQ_CMP) ? rank : ORD_LT;
          out_ovf_r    <= is_upd && y_ovf;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_year          = out_year_r;
  assign out_month         = out_month_r;
  assign out_day           = out_day_r;
  assign out_hour          = out_hour_r;
  assign out_minute        = out_minute_r;
  assign out_second        = out_second_r;
  assign out_order         = out_order_r;
  assign out_year_overflow = out_ovf_r;

  assign fields_legal = (month_reg_r <= MONTH_LAST) && (hour_reg_r < 5'(HOUR_PER_DAY)) &&
                        (minute_reg_r < 6'(SEC_PER_MIN)) && (second_reg_r < 6'(SEC_PER_MIN));

  `CTA_ASSERT(a_time_fields_legal, fields_legal)
  `CTA_ASSERT(a_day_in_month, day_reg_r < days_of(month_reg_r, year_reg_r[1:0] == 2'b00))
  `CTA_ASSERT_IMP(a_divider_active, state_r == S_DIVW, div_sts.busy || div_sts.done)
  `CTA_ASSERT_IMP(a_ovf_no_order, out_valid_r && out_ovf_r, out_order_r == ORD_LT)

endmodule

// ===== hdl/cta_divc.sv =====
// Divider by 60 or 24: quarter the dividend, multiply by a scaled reciprocal of 15 or 6.
// Start loads the dividend; busy loads the quotient, valid at done. Depends on cta_pkg.
module cta_divc
  import cta_pkg::*;
#(
  parameter int WIDTH = DIV_W_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [WIDTH-1:0] dividend,
  output div_sts_t         sts,
  output logic [WIDTH-1:0] quotient,
  output logic [5:0]       remainder
);

  localparam int QW = WIDTH - 4;
  localparam int PW = 2 * WIDTH - 2;
  localparam longint unsigned D_MIN  = SEC_PER_MIN / 4;
  localparam longint unsigned D_HOUR = HOUR_PER_DAY / 4;
  localparam longint unsigned SCALE  = 64'd1 << (WIDTH + 2);
  localparam logic [WIDTH-1:0] RECIP_MIN  = WIDTH'((SCALE + D_MIN - 1) / D_MIN);
  localparam logic [WIDTH-1:0] RECIP_HOUR = WIDTH'((SCALE + D_HOUR - 1) / D_HOUR);

  logic [WIDTH-1:0] x_r;
  logic [QW-1:0]    q_r;
  logic             busy_r;
  logic             done_r;
  logic             by_hour_r;

  logic [WIDTH-3:0] x_quarter;
  logic [WIDTH-1:0] recip;
  logic [PW-1:0]    prod;
  logic [WIDTH-1:0] q_ext;
  logic [WIDTH-1:0] q_times_d;
  logic [WIDTH-1:0] rem_full;

  assign x_quarter = x_r[WIDTH-1:2];
  assign recip     = by_hour_r ? RECIP_HOUR : RECIP_MIN;
  assign prod      = {{WIDTH{1'b0}}, x_quarter} * {{(WIDTH-2){1'b0}}, recip};
  assign q_ext     = {4'b0000, q_r};
  assign q_times_d = by_hour_r ? q_ext * WIDTH'(DIV_HOUR) : q_ext * WIDTH'(DIV_MIN);
  assign rem_full  = x_r - q_times_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= ctl.start;
      done_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x_r       <= dividend;
      by_hour_r <= ctl.by_hour;
    end
    if (busy_r) begin
      q_r <= prod[PW-1:WIDTH+2];
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = q_ext;
  assign remainder = rem_full[5:0];

endmodule

// ===== test/tb_calendar_time_adjust.sv =====
`timescale 1ns / 100ps
// Self-checking bench for calendar_time_adjust: set, add-seconds and compare requests
// checked field by field against a calendar predictor kept in the bench.
// Depends on cta_pkg and the calendar_time_adjust RTL.
module tb_calendar_time_adjust;
  import cta_pkg::*;

  localparam int YB = 14;
  localparam int DB = 21;
  localparam longint YEAR_TOP = (longint'(1) << YB) - 1;
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned HOLD_AFTER = 400;
  localparam int unsigned HOLD_CYCLES = 700;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct {
    logic [1:0]    req;
    logic [YB-1:0] year;
    logic [3:0]    month;
    logic [4:0]    day;
    logic [4:0]    hour;
    logic [5:0]    minute;
    logic [5:0]    second;
    logic [DB-1:0] delta;
    int unsigned   gap;
  } request_t;

  typedef struct packed {
    logic [YB-1:0] year;
    logic [3:0]    month;
    logic [4:0]    day;
    logic [4:0]    hour;
    logic [5:0]    minute;
    logic [5:0]    second;
    logic [1:0]    order;
    logic          ovf;
  } reading_t;

  typedef struct {
    longint y, mo, dy, hr, mt, sc;
  } stamp_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [1:0]    in_req_type = REQ_SET;
  logic [YB-1:0] in_year = '0;
  logic [3:0]    in_month = 4'd1;
  logic [4:0]    in_day = 5'd1;
  logic [4:0]    in_hour = '0;
  logic [5:0]    in_minute = '0;
  logic [5:0]    in_second = '0;
  logic [DB-1:0] in_delta_seconds = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [YB-1:0] out_year;
  logic [3:0]    out_month;
  logic [4:0]    out_day;
  logic [4:0]    out_hour;
  logic [5:0]    out_minute;
  logic [5:0]    out_second;
  logic [1:0]    out_order;
  logic          out_year_overflow;

  request_t    pending[$];
  reading_t    due_readings[$];
  request_t    on_bus;
  stamp_t      clock_state;
  logic        in_took = 1'b0;
  logic        out_took = 1'b0;
  int unsigned wait_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        hold_used = 1'b0;
  logic        hold_on;
  int unsigned cycles = 0;
  int unsigned results_done = 0;
  int unsigned errors = 0;
  int unsigned req_seen[4];
  int unsigned ord_seen[3];
  int unsigned ovf_seen = 0;

  calendar_time_adjust i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_year           (in_year),
    .in_month          (in_month),
    .in_day            (in_day),
    .in_hour           (in_hour),
    .in_minute         (in_minute),
    .in_second         (in_second),
    .in_delta_seconds  (in_delta_seconds),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_year          (out_year),
    .out_month         (out_month),
    .out_day           (out_day),
    .out_hour          (out_hour),
    .out_minute        (out_minute),
    .out_second        (out_second),
    .out_order         (out_order),
    .out_year_overflow (out_year_overflow)
  );

  always #6 clk = ~clk;

  function automatic longint month_days(longint mo, longint y);
    if (mo == longint'(MONTH_FEB)) begin
      return ((y & 3) == 0) ? 29 : 28;
    end
    return longint'(MONTH_LEN[mo]);
  endfunction

  function automatic longint floor_div(longint v, longint d, output longint r);
    longint q;
    q = v / d;
    r = v % d;
    if (r < 0) begin
      r += d;
      q--;
    end
    return q;
  endfunction

  function automatic stamp_t settle(stamp_t t);
    longint r;
    t.mt += floor_div(t.sc, SEC_PER_MIN, r);
    t.sc = r;
    t.hr += floor_div(t.mt, SEC_PER_MIN, r);
    t.mt = r;
    t.dy += floor_div(t.hr, HOUR_PER_DAY, r);
    t.hr = r;
    t.y += floor_div(t.mo, 12, r);
    t.mo = r;
    while (t.dy < 0) begin
      if (t.mo == 0) begin
        t.mo = longint'(MONTH_LAST);
        t.y--;
      end else begin
        t.mo--;
      end
      t.dy += month_days(t.mo, t.y);
    end
    while (t.dy >= month_days(t.mo, t.y)) begin
      t.dy -= month_days(t.mo, t.y);
      if (t.mo == longint'(MONTH_LAST)) begin
        t.mo = 0;
        t.y++;
      end else begin
        t.mo++;
      end
    end
    return t;
  endfunction

  function automatic logic [1:0] rank(longint a, longint b);
    return (a < b) ? ORD_LT : ((a > b) ? ORD_GT : ORD_EQ);
  endfunction

  function automatic reading_t advance_calendar(request_t q);
    reading_t res;
    stamp_t   g;
    stamp_t   n;
    longint   delta;
    logic [1:0] ord;
    logic     ovf;
    delta = $signed(q.delta);
    g.y = q.year;
    g.mo = longint'(q.month) - 1;
    g.dy = longint'(q.day) - 1;
    g.hr = q.hour;
    g.mt = q.minute;
    g.sc = q.second;
    ord = ORD_LT;
    ovf = 1'b0;
    if (q.req == REQ_SET || q.req == REQ_ADD) begin
      if (q.req == REQ_ADD) begin
        g = clock_state;
        g.sc += delta;
      end
      n = settle(g);
      if (n.y < 0 || n.y > YEAR_TOP) begin
        ovf = 1'b1;
      end else begin
        clock_state = n;
      end
    end else if (q.req == REQ_CMP) begin
      n = settle(g);
      ord = rank(clock_state.y, n.y);
      if (ord == ORD_EQ) ord = rank(clock_state.mo, n.mo);
      if (ord == ORD_EQ) ord = rank(clock_state.dy, n.dy);
      if (ord == ORD_EQ) ord = rank(clock_state.hr, n.hr);
      if (ord == ORD_EQ) ord = rank(clock_state.mt, n.mt);
      if (ord == ORD_EQ) ord = rank(clock_state.sc, n.sc);
    end
    res.year = YB'(clock_state.y);
    res.month = 4'(clock_state.mo + 1);
    res.day = 5'(clock_state.dy + 1);
    res.hour = 5'(clock_state.hr);
    res.minute = 6'(clock_state.mt);
    res.second = 6'(clock_state.sc);
    res.order = ord;
    res.ovf = ovf;
    return res;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  function automatic void queue_item(logic [1:0] req, int y, int mo, int d, int h, int mi,
                                     int s, int dl);
    request_t q;
    q.req = req;
    q.year = YB'(y);
    q.month = 4'(mo);
    q.day = 5'(d);
    q.hour = 5'(h);
    q.minute = 6'(mi);
    q.second = 6'(s);
    q.delta = DB'(dl);
    q.gap = ((pending.size() / 150) % 3 == 2) ? 0 : $urandom_range(0, 18);
    pending.push_back(q);
  endfunction

  function automatic int rand_year();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return $urandom_range(0, 2);
    if (pick == 1) return $urandom_range(YEAR_TOP - 2, YEAR_TOP);
    return $urandom_range(0, YEAR_TOP);
  endfunction

  function automatic int rand_delta();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return $urandom_range(0, 200) - 100;
    if (pick < 7) return $urandom_range(0, 200000) - 100000;
    return $urandom_range(0, (1 << DB) - 1);
  endfunction

  always @(negedge clk) begin : feed
    request_t nxt;
    logic     drive;
    if (!rst_n) begin
      in_valid <= 1'b0;
      wait_left <= 0;
    end else if (!in_valid || in_took) begin
      drive = 1'b0;
      if (wait_left != 0) begin
        wait_left <= wait_left - 1;
      end else if (pending.size() != 0) begin
        nxt = pending.pop_front();
        drive = 1'b1;
        on_bus <= nxt;
        in_req_type <= nxt.req;
        in_year <= nxt.year;
        in_month <= nxt.month;
        in_day <= nxt.day;
        in_hour <= nxt.hour;
        in_minute <= nxt.minute;
        in_second <= nxt.second;
        in_delta_seconds <= nxt.delta;
        wait_left <= nxt.gap;
      end
      in_valid <= drive;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (!hold_used && results_done >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  assign hold_on = (hold_left != 0);

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_took) begin
        stall_left = ((results_done / 120) % 3 == 1) ? 0 : $urandom_range(0, 18);
      end else if (out_valid && stall_left != 0) begin
        stall_left = stall_left - 1;
      end
      out_stall <= hold_on || (stall_left != 0);
    end
  end

  always @(posedge clk) begin : watch
    reading_t want;
    reading_t got;
    if (!rst_n) begin
      in_took <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      out_took <= out_valid && !out_stall;
      if (out_valid && !out_stall) begin
        if (due_readings.size() == 0) begin
          $display("%0t ns: result year %0d with no request outstanding", $time, out_year);
          errors++;
        end else begin
          want = due_readings.pop_front();
          check_field("year", want.year, out_year);
          check_field("month", want.month, out_month);
          check_field("day", want.day, out_day);
          check_field("hour", want.hour, out_hour);
          check_field("minute", want.minute, out_minute);
          check_field("second", want.second, out_second);
          check_field("order", want.order, out_order);
          check_field("year_overflow", want.ovf, out_year_overflow);
          results_done++;
        end
      end
      if (in_valid && !in_stall) begin
        got = advance_calendar(on_bus);
        due_readings.push_back(got);
        req_seen[on_bus.req]++;
        if (on_bus.req == REQ_CMP) ord_seen[got.order]++;
        if (got.ovf) ovf_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t ns: run stopped at the cycle limit", $time);
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int k;
    int pick;
    int y, mo, d, h, mi, s;
    int cy, cmo, cd, ch, cmi, cs;
    int step;
    int j;
    clock_state = '{0, 0, 0, 0, 0, 0};

    queue_item(REQ_SET, 2024, 2, 29, 23, 59, 59, 0);
    queue_item(REQ_ADD, 0, 1, 1, 0, 0, 0, 1);
    queue_item(REQ_CMP, 2024, 3, 1, 0, 0, 0, 0);
    queue_item(REQ_CMP, 2024, 2, 30, 0, 0, 1, 0);
    queue_item(REQ_CMP, 2024, 2, 29, 23, 59, 59, 0);
    queue_item(REQ_ADD, 0, 1, 1, 0, 0, 0, -1048576);
    queue_item(REQ_ADD, 0, 1, 1, 0, 0, 0, 1048575);
    queue_item(REQ_NONE, YEAR_TOP, 15, 31, 31, 63, 63, -1);
    queue_item(REQ_SET, 0, 1, 1, 0, 0, 0, 0);
    queue_item(REQ_ADD, 0, 1, 1, 0, 0, 0, -1);
    queue_item(REQ_SET, 0, 0, 1, 0, 0, 0, 0);
    queue_item(REQ_SET, YEAR_TOP, 12, 31, 23, 59, 59, 0);
    queue_item(REQ_ADD, 0, 1, 1, 0, 0, 0, 1);
    queue_item(REQ_CMP, YEAR_TOP, 15, 31, 31, 63, 63, 0);
    queue_item(REQ_CMP, 0, 0, 0, 0, 0, 0, 0);
    queue_item(REQ_SET, YEAR_TOP, 13, 1, 0, 0, 0, 0);
    queue_item(REQ_SET, 1900, 2, 29, 0, 0, 0, 0);
    queue_item(REQ_SET, 2023, 2, 29, 0, 0, 0, 0);
    queue_item(REQ_SET, 2023, 4, 31, 12, 30, 30, 0);
    queue_item(REQ_SET, 2023, 3, 0, 0, 0, 0, 0);
    queue_item(REQ_SET, 2023, 15, 31, 31, 63, 63, 0);
    queue_item(REQ_SET, 2020, 0, 0, 0, 0, 0, 0);
    queue_item(REQ_ADD, 0, 1, 1, 0, 0, 0, 0);

    k = 0;
    while (k < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      y = rand_year();
      mo = $urandom_range(1, 12);
      d = $urandom_range(1, 31);
      h = $urandom_range(0, 23);
      mi = $urandom_range(0, 59);
      s = $urandom_range(0, 59);
      if (pick < 20) begin
        queue_item(REQ_SET, y, mo, d, h, mi, s, rand_delta());
        cy = y; cmo = mo; cd = d; ch = h; cmi = mi; cs = s;
        step = $urandom_range(0, 1) ? 1 : -1;
        case ($urandom_range(0, 6))
          0: cy += step;
          1: cmo += step;
          2: cd += step;
          3: ch += step;
          4: cmi += step;
          5: cs += step;
          default: ;
        endcase
        queue_item(REQ_CMP, cy, cmo, cd, ch, cmi, cs, rand_delta());
        k += 2;
      end else if (pick < 28) begin
        queue_item(REQ_SET, $urandom_range(0, YEAR_TOP), $urandom_range(0, 15),
                   $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 63),
                   $urandom_range(0, 63), rand_delta());
        k++;
      end else if (pick < 70) begin
        queue_item(REQ_ADD, $urandom_range(0, YEAR_TOP), $urandom_range(0, 15),
                   $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 63),
                   $urandom_range(0, 63), rand_delta());
        k++;
      end else if (pick < 88) begin
        queue_item(REQ_CMP, y, $urandom_range(0, 15), $urandom_range(0, 31),
                   $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
                   rand_delta());
        k++;
      end else if (pick < 92) begin
        queue_item(REQ_NONE, y, mo, d, h, mi, s, rand_delta());
        k++;
      end else begin
        if ($urandom_range(0, 1)) begin
          queue_item(REQ_SET, YEAR_TOP, 12, $urandom_range(17, 31), h, mi, s, 0);
        end else begin
          queue_item(REQ_SET, 0, 1, $urandom_range(1, 14), h, mi, s, 0);
        end
        for (j = 0; j < 3; j++) begin
          queue_item(REQ_ADD, y, mo, d, h, mi, s, rand_delta());
        end
        k += 4;
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (due_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d set, %0d add, %0d compare, %0d unused code.",
             results_done, req_seen[REQ_SET], req_seen[REQ_ADD], req_seen[REQ_CMP],
             req_seen[REQ_NONE]);
    $display("Year range exceeded %0d times; compares earlier %0d, equal %0d, later %0d.",
             ovf_seen, ord_seen[ORD_LT], ord_seen[ORD_EQ], ord_seen[ORD_GT]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
